// ===== src/gbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types, S-box tables and round helpers of the block cipher core.
// ----------------------------------------------------------------------------
package gbc_pkg;

   localparam int ROUNDS    = 32;
   localparam int ROT       = 11;
   localparam int KEY_WORDS = 8;
   localparam int HALF_W    = 32;
   localparam int CSR_IDX_W = 4;

   typedef logic [HALF_W-1:0] half_type;
   typedef half_type key_array_type [KEY_WORDS];

   // word in flight: direction plus the two halves; half_a feeds the round function
   typedef struct packed {
      logic     kind;
      half_type half_a;
      half_type half_b;
   } stage_type;

   localparam logic [3:0] SBOX_ROWS [8][16] = '{
      '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
        4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
      '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
        4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
      '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
        4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
      '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
        4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
      '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
        4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
      '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
        4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
      '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
        4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
      '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
        4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7}
   };

   // substitute each nibble (row 7 takes nibble 0), then rotate left
   function automatic half_type round_fn(input half_type v);
      half_type s;
      s = '0;
      for (int nib = 0; nib < 8; nib++) begin
         s[nib*4 +: 4] = SBOX_ROWS[7-nib][v[nib*4 +: 4]];
      end
      return {s[HALF_W-ROT-1:0], s[HALF_W-1:HALF_W-ROT]};
   endfunction

   function automatic logic [2:0] key_index(input logic encrypt, input logic [4:0] rnd);
      logic forward;
      forward = encrypt ? (rnd < 5'd24) : (rnd < 5'd8);
      return forward ? rnd[2:0] : ~rnd[2:0];
   endfunction

endpackage

// ===== src/gbc_round.sv =====
// ----------------------------------------------------------------------------
// gbc_round
// One Feistel round with its stage register and valid/ready flow control.
// ----------------------------------------------------------------------------
module gbc_round (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  gbc_pkg::stage_type up_word,
   input  gbc_pkg::half_type  key_word,
   output logic               down_valid,
   input  logic               down_ready,
   output gbc_pkg::stage_type down_word
);

   logic               valid_ff, valid_in;
   gbc_pkg::stage_type word_ff, word_in;
   logic               load;

   always_comb begin
      up_ready = !valid_ff || down_ready;
      load     = up_valid && up_ready;
      valid_in = up_ready ? up_valid : valid_ff;
      word_in.kind   = up_word.kind;
      word_in.half_a = up_word.half_b ^ gbc_pkg::round_fn(up_word.half_a + key_word);
      word_in.half_b = up_word.half_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule

// ===== src/gost_block_cipher_ecb_core.sv =====
// ----------------------------------------------------------------------------
// gost_block_cipher_ecb_core
// GOST 28147-89 block cipher, ECB, one 64-bit word per cycle unless stalled.
// ----------------------------------------------------------------------------
// The core runs 32 cipher rounds in 32 register stages, one round per stage,
// and a new word may be accepted every cycle unless back-pressure stalls it.
// Each stage holds its own valid bit and only stalls while full and blocked
// downstream, so bubbles close up under back-pressure.
// Key words 0..7 are written through the csr_ port at indices 0..7 while the
// core is idle (user's rule, not enforced); other indices are ignored.
module gost_block_cipher_ecb_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [63:0]                     req_data_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [63:0]                     rsp_data_out,
   input  logic                            csr_write_enable,
   input  logic [gbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_write_data
);

   gbc_pkg::key_array_type key_ff;
   gbc_pkg::stage_type     stage_word  [gbc_pkg::ROUNDS+1];
   logic                   stage_valid [gbc_pkg::ROUNDS+1];
   logic                   stage_ready [gbc_pkg::ROUNDS+1];
   gbc_pkg::half_type      stage_key   [gbc_pkg::ROUNDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gbc_pkg::KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_write_enable &&
                   (csr_index < gbc_pkg::CSR_IDX_W'(gbc_pkg::KEY_WORDS))) begin
         key_ff[csr_index[2:0]] <= csr_write_data;
      end
   end

   assign stage_valid[0] = req_valid;
   assign stage_word[0]  = {req_kind, req_data_in[31:0], req_data_in[63:32]};

   assign req_ready                      = stage_ready[0];
   assign stage_ready[gbc_pkg::ROUNDS]   = rsp_ready;

   for (genvar g = 0; g < gbc_pkg::ROUNDS; g++) begin : g_round
      assign stage_key[g] = key_ff[gbc_pkg::key_index(stage_word[g].kind, 5'(g))];

      gbc_round u_round (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (stage_valid[g]),
         .up_ready   (stage_ready[g]),
         .up_word    (stage_word[g]),
         .key_word   (stage_key[g]),
         .down_valid (stage_valid[g+1]),
         .down_ready (stage_ready[g+1]),
         .down_word  (stage_word[g+1])
      );
   end

   assign rsp_valid    = stage_valid[gbc_pkg::ROUNDS];
   assign rsp_data_out = {stage_word[gbc_pkg::ROUNDS].half_a,
                          stage_word[gbc_pkg::ROUNDS].half_b};

endmodule
